FILE: hw/rtl/bvm_pkg.sv
// Shared types and constants of the byte VM execute unit.
// Used by the channel interfaces, every RTL module and the checker.
`timescale 1ns / 1ps

package bvm_pkg;

    // Sizing of the machine state
    localparam int DATA_BYTES  = 4;
    localparam int STACK_DEPTH = 16;
    localparam int REG_COUNT   = 4;

    localparam int REG_IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DATA_IDX_W  = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 17;
    localparam int IP_W     = 9;
    localparam int STATUS_W = 3;
    localparam int FLAG_W   = 2;

    localparam logic [BYTE_W-1:0] BYTE_MAX       = 8'hFF;
    localparam logic [BYTE_W-1:0] CODE_LIMIT_RST = 8'd88;
    localparam logic [IP_W-1:0]   IP_STEP        = 9'd3;

    // Divider runs one quotient bit per cycle
    localparam int DIV_STEPS = BYTE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [BYTE_W-1:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_MUL  = 8'd2,
        OP_DIV  = 8'd3,
        OP_MOD  = 8'd4,
        OP_STP  = 8'd5,
        OP_LDI  = 8'd6,
        OP_ADR  = 8'd7,
        OP_SUR  = 8'd8,
        OP_INC  = 8'd9,
        OP_DEC  = 8'd10,
        OP_JMP  = 8'd11,
        OP_CMP  = 8'd12,
        OP_JE   = 8'd13,
        OP_STI  = 8'd14,
        OP_LDM  = 8'd15,
        OP_PUSH = 8'd16,
        OP_POP  = 8'd17
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN    = 3'd0,
        ST_STOP   = 3'd1,
        ST_END    = 3'd2,
        ST_BADOP  = 3'd3,
        ST_BADREG = 3'd4,
        ST_OVER   = 3'd5,
        ST_UNDER  = 3'd6
    } status_t;

    typedef enum logic [FLAG_W-1:0] {
        FLAG_POS = 2'd0,
        FLAG_EQ  = 2'd1,
        FLAG_NEG = 2'd2
    } flag_t;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic commit_exec;
        logic start_div;
        logic commit_div;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic needs_div;
        logic div_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: hw/rtl/bvm_if.sv
// Valid/ready channel interfaces: instruction in, result out.
// Depends on bvm_pkg.
`timescale 1ns / 1ps

interface bvm_instr_if;
    import bvm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] func;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] right;

    modport source (output valid, output func, output left, output right, input ready);
    modport sink   (input valid, input func, input left, input right, output ready);
endinterface

interface bvm_result_if;
    import bvm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [IP_W-1:0]           next_ip;
    status_t                   status;
    logic [BYTE_W-1:0]         exit_code;

    modport source (output valid, output value, output next_ip, output status,
                    output exit_code, input ready);
    modport sink   (input valid, input value, input next_ip, input status,
                    input exit_code, output ready);
endinterface

FILE: hw/rtl/bvm_divider.sv
// Bit-serial restoring divider, 8-bit by 8-bit, one quotient bit per cycle.
// Depends on bvm_pkg. Divisor is nonzero whenever started.
`timescale 1ns / 1ps

module bvm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bvm_pkg::BYTE_W-1:0]  dividend,
    input  logic [bvm_pkg::BYTE_W-1:0]  divisor,
    output logic                        busy,
    output logic [bvm_pkg::BYTE_W-1:0]  quotient,
    output logic [bvm_pkg::BYTE_W-1:0]  remainder
);
    import bvm_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BYTE_W-1:0]    quo_reg;
    logic [BYTE_W-1:0]    rem_reg;
    logic [BYTE_W-1:0]    dvs_reg;
    logic [BYTE_W:0]      shifted;
    logic [BYTE_W:0]      trial;
    logic                 fits;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[BYTE_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[BYTE_W-2:0], fits};
            rem_reg <= fits ? trial[BYTE_W-1:0] : shifted[BYTE_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/bvm_controller.sv
// Sequencing of the execute unit: instructions committed on acceptance and divide waits.
// Depends on bvm_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module bvm_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bvm_pkg::ctrl_status_t sts,
    output bvm_pkg::ctrl_cmd_t    cmd
);
    import bvm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = sts.out_free;
                if (sts.in_valid && sts.out_free)
                begin
                    if (sts.needs_div)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.commit_exec = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy && sts.out_free)
                begin
                    cmd.commit_div = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bvm_datapath.sv
// Machine state, instruction decode and execute, result register, divider.
// Depends on bvm_pkg, bvm_if and bvm_divider; sequenced by bvm_controller.
`timescale 1ns / 1ps

module bvm_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bvm_pkg::BYTE_W-1:0] cfg_wr_data,
    bvm_instr_if.sink                  instr,
    bvm_result_if.source               result,
    input  bvm_pkg::ctrl_cmd_t         cmd,
    output bvm_pkg::ctrl_status_t      sts
);
    import bvm_pkg::*;

    // Architectural state
    logic [BYTE_W-1:0]      gp_regs_reg [REG_COUNT];
    logic [BYTE_W-1:0]      data_mem_reg [DATA_BYTES];
    logic [BYTE_W-1:0]      stack_mem_reg [STACK_DEPTH];
    logic [STACK_CNT_W-1:0] stack_cnt_reg;
    flag_t                  cmp_flag_reg;
    logic [IP_W-1:0]        ip_reg;
    logic                   halted_reg;
    logic [BYTE_W-1:0]      code_limit_reg;
    logic                   div_mod_reg;

    // Result register
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     out_value_reg;
    logic [IP_W-1:0]        out_next_ip_reg;
    status_t                out_status_reg;
    logic [BYTE_W-1:0]      out_exit_reg;

    // Decode / execute
    logic [BYTE_W-1:0]      l;
    logic [BYTE_W-1:0]      r;
    logic [IP_W-1:0]        ip_seq;
    logic                   at_end;
    logic                   l_reg_ok;
    logic                   r_reg_ok;
    logic                   l_mem_ok;
    logic                   r_mem_ok;
    logic [BYTE_W-1:0]      reg_l;
    logic [BYTE_W-1:0]      cmp_a;
    logic [BYTE_W-1:0]      cmp_b;
    logic [2*BYTE_W-1:0]    product;
    logic [STACK_CNT_W-1:0] top_idx;
    logic [BYTE_W-1:0]      alu_v;

    logic [VALUE_W-1:0]     ex_value;
    logic [IP_W-1:0]        ex_next;
    status_t                ex_status;
    logic [BYTE_W-1:0]      ex_exit;
    logic                   reg_we;
    logic [BYTE_W-1:0]      reg_wdata;
    logic                   cmp_we;
    flag_t                  cmp_wdata;
    logic                   mem_we;
    logic                   push;
    logic                   pop;

    logic                   div_busy;
    logic [BYTE_W-1:0]      div_quo;
    logic [BYTE_W-1:0]      div_rem;
    logic                   out_free;

    assign l         = instr.left;
    assign r         = instr.right;
    assign ip_seq    = ip_reg + IP_STEP;
    assign at_end    = ip_reg >= {1'b0, code_limit_reg};
    assign l_reg_ok  = l < BYTE_W'(REG_COUNT);
    assign r_reg_ok  = r < BYTE_W'(REG_COUNT);
    assign l_mem_ok  = l < BYTE_W'(DATA_BYTES);
    assign r_mem_ok  = r < BYTE_W'(DATA_BYTES);
    assign reg_l     = l_reg_ok ? gp_regs_reg[l[REG_IDX_W-1:0]] : BYTE_MAX;
    assign cmp_a     = reg_l;
    assign cmp_b     = r_reg_ok ? gp_regs_reg[r[REG_IDX_W-1:0]] : BYTE_MAX;
    assign product   = (2*BYTE_W)'(l) * (2*BYTE_W)'(r);
    assign top_idx   = stack_cnt_reg - STACK_CNT_W'(1);

    // Register-update ALU for LDI / ADR / SUR / INC / DEC
    always_comb
    begin
        case (op_t'(instr.func))
            OP_LDI:  alu_v = r;
            OP_ADR:  alu_v = reg_l + r;
            OP_SUR:  alu_v = reg_l - r;
            OP_INC:  alu_v = reg_l + BYTE_W'(1);
            default: alu_v = reg_l - BYTE_W'(1);
        endcase
    end

    // Combinational execute
    always_comb
    begin
        ex_value  = '0;
        ex_next   = ip_seq;
        ex_status = ST_RUN;
        ex_exit   = '0;
        reg_we    = 1'b0;
        reg_wdata = alu_v;
        cmp_we    = 1'b0;
        cmp_wdata = FLAG_POS;
        mem_we    = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        if (halted_reg)
        begin
            ex_status = ST_STOP;
            ex_next   = ip_reg;
        end
        else if (at_end)
        begin
            ex_status = ST_END;
            ex_next   = ip_reg;
        end
        else
        begin
            case (op_t'(instr.func))
                OP_ADD: ex_value = VALUE_W'(l) + VALUE_W'(r);
                OP_SUB: ex_value = VALUE_W'(l) - VALUE_W'(r);
                OP_MUL: ex_value = VALUE_W'(product);
                // nonzero divisor goes to the divider; zero divisor gives 0
                OP_DIV, OP_MOD: ex_value = '0;
                OP_STP:
                begin
                    ex_status = ST_STOP;
                    ex_exit   = l;
                    ex_value  = VALUE_W'(l);
                end
                OP_LDI, OP_ADR, OP_SUR, OP_INC, OP_DEC:
                begin
                    if (!l_reg_ok)
                    begin
                        ex_status = ST_BADREG;
                    end
                    else
                    begin
                        reg_we   = 1'b1;
                        ex_value = VALUE_W'(alu_v);
                    end
                end
                OP_JMP:
                begin
                    ex_next  = IP_W'(l);
                    ex_value = VALUE_W'(l);
                end
                OP_CMP:
                begin
                    cmp_we = 1'b1;
                    if (cmp_a == cmp_b)
                    begin
                        cmp_wdata = FLAG_EQ;
                    end
                    else if (cmp_a < cmp_b)
                    begin
                        cmp_wdata = FLAG_NEG;
                    end
                    ex_value = VALUE_W'(cmp_wdata);
                end
                OP_JE:
                begin
                    if (cmp_flag_reg == FLAG_EQ)
                    begin
                        ex_next  = IP_W'(l);
                        ex_value = VALUE_W'(l);
                    end
                    else
                    begin
                        ex_value = VALUE_W'(BYTE_MAX);
                    end
                end
                OP_STI:
                begin
                    mem_we   = l_mem_ok;
                    ex_value = l_mem_ok ? VALUE_W'(r) : VALUE_W'(BYTE_MAX);
                end
                OP_LDM:
                begin
                    if (r_mem_ok)
                    begin
                        reg_we    = l_reg_ok;
                        reg_wdata = data_mem_reg[r[DATA_IDX_W-1:0]];
                        ex_value  = l_reg_ok ? VALUE_W'(reg_wdata) : VALUE_W'(BYTE_MAX);
                    end
                    else
                    begin
                        ex_value = VALUE_W'(BYTE_MAX);
                    end
                end
                OP_PUSH:
                begin
                    if (stack_cnt_reg >= STACK_CNT_W'(STACK_DEPTH))
                    begin
                        ex_status = ST_OVER;
                    end
                    else
                    begin
                        push     = 1'b1;
                        ex_value = VALUE_W'(l);
                    end
                end
                OP_POP:
                begin
                    if (stack_cnt_reg == '0)
                    begin
                        ex_status = ST_UNDER;
                    end
                    else
                    begin
                        pop       = 1'b1;
                        reg_we    = l_reg_ok;
                        reg_wdata = stack_mem_reg[top_idx[STACK_IDX_W-1:0]];
                        ex_value  = l_reg_ok ? VALUE_W'(reg_wdata) : VALUE_W'(BYTE_MAX);
                    end
                end
                default: ex_status = ST_BADOP;
            endcase
        end
    end

    // Status toward the controller
    assign out_free      = !out_valid_reg || result.ready;
    assign sts.in_valid  = instr.valid;
    assign sts.out_free  = out_free;
    assign sts.div_busy  = div_busy;
    assign sts.needs_div = !halted_reg && !at_end && (r != '0)
                           && ((op_t'(instr.func) == OP_DIV) || (op_t'(instr.func) == OP_MOD));

    assign instr.ready = cmd.in_ready;

    bvm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (l),
        .divisor   (r),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Control state: ip, flags, halt, stack pointer, registers, data bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_limit_reg <= CODE_LIMIT_RST;
            ip_reg         <= '0;
            halted_reg     <= 1'b0;
            cmp_flag_reg   <= FLAG_POS;
            stack_cnt_reg  <= '0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                gp_regs_reg[i] <= '0;
            end
            for (int i = 0; i < DATA_BYTES; i++)
            begin
                data_mem_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                code_limit_reg <= cfg_wr_data;
            end
            if (cmd.commit_exec)
            begin
                ip_reg     <= ex_next;
                halted_reg <= halted_reg || (ex_status != ST_RUN);
                if (cmp_we)
                begin
                    cmp_flag_reg <= cmp_wdata;
                end
                if (reg_we)
                begin
                    gp_regs_reg[l[REG_IDX_W-1:0]] <= reg_wdata;
                end
                if (mem_we)
                begin
                    data_mem_reg[l[DATA_IDX_W-1:0]] <= r;
                end
                if (push)
                begin
                    stack_cnt_reg <= stack_cnt_reg + STACK_CNT_W'(1);
                end
                else if (pop)
                begin
                    stack_cnt_reg <= top_idx;
                end
            end
            else if (cmd.commit_div)
            begin
                ip_reg <= ip_seq;
            end
        end
    end

    // Stack storage and divide/modulo select
    always_ff @(posedge clk)
    begin
        if (cmd.commit_exec && push)
        begin
            stack_mem_reg[stack_cnt_reg[STACK_IDX_W-1:0]] <= l;
        end
        if (cmd.start_div)
        begin
            div_mod_reg <= (op_t'(instr.func) == OP_MOD);
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit_exec || cmd.commit_div)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit_exec)
        begin
            out_value_reg   <= ex_value;
            out_next_ip_reg <= ex_next;
            out_status_reg  <= ex_status;
            out_exit_reg    <= ex_exit;
        end
        else if (cmd.commit_div)
        begin
            out_value_reg   <= VALUE_W'(div_mod_reg ? div_rem : div_quo);
            out_next_ip_reg <= ip_seq;
            out_status_reg  <= ST_RUN;
            out_exit_reg    <= '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.value     = out_value_reg;
    assign result.next_ip   = out_next_ip_reg;
    assign result.status    = out_status_reg;
    assign result.exit_code = out_exit_reg;

endmodule

FILE: hw/rtl/byte_vm_instruction_execute.sv
// Execute unit of the byte VM: one fetched instruction in, one result out.
// Every instruction other than DIV or MOD with a nonzero divisor is accepted
// and executed in the same cycle, so the unit takes one transaction per clock
// as long as the result side keeps up and no divide is pending; the result
// sits in an output register, and a new instruction is taken in the same
// cycle the previous result is taken. DIV and MOD with a nonzero divisor
// take longer: the accept cycle loads the bit-serial divider, which then
// produces one quotient bit per cycle, and the result register is loaded once
// the divider is done and the result side is free; no instruction is taken meanwhile.
// code_limit may only be written while no transaction is in flight.
// Depends on bvm_pkg, bvm_if, bvm_controller, bvm_datapath.
`timescale 1ns / 1ps

module byte_vm_instruction_execute (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bvm_pkg::BYTE_W-1:0] cfg_wr_data,
    bvm_instr_if.sink                  instr,
    bvm_result_if.source               result
);
    import bvm_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t sts;

    // Sequencer
    bvm_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // State, execute logic and result register
    bvm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .instr       (instr),
        .result      (result),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: hw/rtl/bvm_checker.sv
// Port-level checks of the execute unit, attached by bind.
// Depends on bvm_pkg and byte_vm_instruction_execute.
`timescale 1ns / 1ps

module bvm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [bvm_pkg::VALUE_W-1:0]  out_value,
    input logic [bvm_pkg::IP_W-1:0]            out_next_ip,
    input logic [bvm_pkg::STATUS_W-1:0]        out_status,
    input logic [bvm_pkg::BYTE_W-1:0]          out_exit_code
);
    import bvm_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
        $stable({out_value, out_next_ip, out_status, out_exit_code}))
        else $error("result payload changed while stalled");

    // No instruction is taken while the result register is blocked
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("instruction taken while result stalled");

    // An accepted instruction gives a result next cycle, or holds off input (divide)
    a_accept_response: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid || !in_ready)
        else $error("accepted instruction produced no result and input stays open");

endmodule

bind byte_vm_instruction_execute bvm_checker u_bvm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (instr.valid),
    .in_ready      (instr.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_value     (result.value),
    .out_next_ip   (result.next_ip),
    .out_status    (result.status),
    .out_exit_code (result.exit_code)
);

FILE: bench/testbench.sv
// Self-checking bench for byte_vm_instruction_execute: a directed table, then
// random programs, checked result by result against a behavioral model.
// Depends on bvm_pkg and the bvm_instr_if / bvm_result_if interfaces.
`timescale 1ns / 1ps

module testbench;
    import bvm_pkg::*;

    localparam int OPCODE_COUNT     = 18;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int END_CYCLES       = 20;
    localparam int LONG_HOLD_AT     = 100;    // random transaction that starts the long stall
    localparam int LONG_HOLD_CYCLES = 64;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [IP_W-1:0]           next_ip;
        status_t                   status;
        logic [BYTE_W-1:0]         exit_code;
    } result_t;

    typedef struct {
        op_t               op;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] right;
        bit                typed;
        result_t           want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [BYTE_W-1:0] cfg_wr_data;

    bvm_instr_if  instr_ch ();
    bvm_result_if result_ch ();

    byte_vm_instruction_execute dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .instr       (instr_ch),
        .result      (result_ch)
    );

    // Model of the machine state
    logic [BYTE_W-1:0] m_regs  [REG_COUNT];
    logic [BYTE_W-1:0] m_dmem  [DATA_BYTES];
    logic [BYTE_W-1:0] m_stack [STACK_DEPTH];
    flag_t             m_flag;
    logic [IP_W-1:0]   m_ip;
    int                m_sp;
    bit                m_halted;
    logic [BYTE_W-1:0] m_limit;

    result_t expected_results [$];
    result_t blank_result;

    int  errors        = 0;
    int  cycle_count   = 0;
    int  total_items   = 0;
    int  random_items  = 0;
    int  halted_items  = 0;
    int  results_seen  = 0;
    int  limit_writes  = 0;
    int  push_burst    = 0;
    int  stall_left    = 0;
    bit  long_hold_req = 1'b0;
    bit  tx_quiet      = 1'b0;
    bit  rx_quiet      = 1'b0;
    status_t ending;

    // Directed program from reset, code_limit 88; ip runs 0..39, 81..87, then 0..30
    directed_row_t directed_rows [27] = '{
        '{OP_ADD,  8'd255, 8'd255, 1'b1, '{17'sd510,   9'd3,  ST_RUN, 8'd0}},
        '{OP_SUB,  8'd0,   8'd255, 1'b1, '{-17'sd255,  9'd6,  ST_RUN, 8'd0}},
        '{OP_MUL,  8'd255, 8'd255, 1'b1, '{17'sd65025, 9'd9,  ST_RUN, 8'd0}},
        '{OP_DIV,  8'd200, 8'd0,   1'b1, '{17'sd0,     9'd12, ST_RUN, 8'd0}},
        '{OP_MOD,  8'd200, 8'd0,   1'b1, '{17'sd0,     9'd15, ST_RUN, 8'd0}},
        '{OP_DIV,  8'd255, 8'd1,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_MOD,  8'd254, 8'd255, 1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_LDI,  8'd3,   8'd255, 1'b1, '{17'sd255,   9'd24, ST_RUN, 8'd0}},
        '{OP_INC,  8'd3,   8'd0,   1'b1, '{17'sd0,     9'd27, ST_RUN, 8'd0}},
        '{OP_DEC,  8'd0,   8'd0,   1'b1, '{17'sd255,   9'd30, ST_RUN, 8'd0}},
        '{OP_ADR,  8'd1,   8'd200, 1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_SUR,  8'd1,   8'd201, 1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_CMP,  8'd0,   8'd1,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_JE,   8'd81,  8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_CMP,  8'd2,   8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_JE,   8'd0,   8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_JMP,  8'd0,   8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_CMP,  8'd9,   8'd2,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_STI,  8'd3,   8'd170, 1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_STI,  8'd4,   8'd1,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_LDM,  8'd2,   8'd3,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_LDM,  8'd7,   8'd3,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_LDM,  8'd0,   8'd4,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_PUSH, 8'd85,  8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_POP,  8'd9,   8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_PUSH, 8'd171, 8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}},
        '{OP_POP,  8'd1,   8'd0,   1'b0, '{17'sd0,     9'd0,  ST_RUN, 8'd0}}
    };

    // Clock: 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Register file access; unmapped registers read as 255 and ignore writes
    function automatic logic [BYTE_W-1:0] reg_read(input logic [BYTE_W-1:0] n);
        return (n < REG_COUNT) ? m_regs[n[REG_IDX_W-1:0]] : BYTE_MAX;
    endfunction

    function automatic void reg_write(input logic [BYTE_W-1:0] n, input logic [BYTE_W-1:0] v);
        if (n < REG_COUNT)
            m_regs[n[REG_IDX_W-1:0]] = v;
    endfunction

    // Execute one instruction on the model state and return its result
    function automatic result_t predict_execute(input logic [BYTE_W-1:0] f, l, r);
        result_t res;
        int diff;
        logic [BYTE_W-1:0] acc;
        res.value     = '0;
        res.next_ip   = m_ip + IP_STEP;
        res.status    = ST_RUN;
        res.exit_code = '0;
        if (m_halted)
        begin
            res.status  = ST_STOP;
            res.next_ip = m_ip;
        end
        else if (m_ip >= {1'b0, m_limit})
        begin
            res.status  = ST_END;
            res.next_ip = m_ip;
            m_halted    = 1'b1;
        end
        else
        begin
            if (f >= OPCODE_COUNT)
                res.status = ST_BADOP;
            else
            begin
                case (op_t'(f))
                    OP_ADD: res.value = 17'(l) + 17'(r);
                    OP_SUB: res.value = 17'(l) - 17'(r);
                    OP_MUL: res.value = 17'(l) * 17'(r);
                    OP_DIV: res.value = (r == 0) ? 17'd0 : 17'(l / r);
                    OP_MOD: res.value = (r == 0) ? 17'd0 : 17'(l % r);
                    OP_STP:
                    begin
                        res.status    = ST_STOP;
                        res.exit_code = l;
                        res.value     = 17'(l);
                    end
                    OP_LDI, OP_ADR, OP_SUR, OP_INC, OP_DEC:
                    begin
                        if (l >= REG_COUNT)
                            res.status = ST_BADREG;
                        else
                        begin
                            acc = m_regs[l[REG_IDX_W-1:0]];
                            case (op_t'(f))
                                OP_LDI:  acc = r;
                                OP_ADR:  acc = acc + r;
                                OP_SUR:  acc = acc - r;
                                OP_INC:  acc = acc + 8'd1;
                                default: acc = acc - 8'd1;
                            endcase
                            m_regs[l[REG_IDX_W-1:0]] = acc;
                            res.value = 17'(acc);
                        end
                    end
                    OP_JMP:
                    begin
                        res.next_ip = {1'b0, l};
                        res.value   = 17'(l);
                    end
                    OP_CMP:
                    begin
                        diff   = int'(reg_read(l)) - int'(reg_read(r));
                        m_flag = (diff == 0) ? FLAG_EQ : ((diff < 0) ? FLAG_NEG : FLAG_POS);
                        res.value = 17'(m_flag);
                    end
                    OP_JE:
                    begin
                        if (m_flag == FLAG_EQ)
                        begin
                            res.next_ip = {1'b0, l};
                            res.value   = 17'(l);
                        end
                        else
                            res.value = 17'(BYTE_MAX);
                    end
                    OP_STI:
                    begin
                        if (l < DATA_BYTES)
                        begin
                            m_dmem[l[DATA_IDX_W-1:0]] = r;
                            res.value = 17'(r);
                        end
                        else
                            res.value = 17'(BYTE_MAX);
                    end
                    OP_LDM:
                    begin
                        if (r < DATA_BYTES)
                        begin
                            reg_write(l, m_dmem[r[DATA_IDX_W-1:0]]);
                            res.value = 17'(reg_read(l));
                        end
                        else
                            res.value = 17'(BYTE_MAX);
                    end
                    OP_PUSH:
                    begin
                        if (m_sp >= STACK_DEPTH)
                            res.status = ST_OVER;
                        else
                        begin
                            m_stack[m_sp] = l;
                            m_sp++;
                            res.value = 17'(l);
                        end
                    end
                    default:
                    begin
                        // pop
                        if (m_sp == 0)
                            res.status = ST_UNDER;
                        else
                        begin
                            m_sp--;
                            reg_write(l, m_stack[m_sp]);
                            res.value = 17'(reg_read(l));
                        end
                    end
                endcase
            end
            if (res.status != ST_RUN)
                m_halted = 1'b1;
            m_ip = res.next_ip;
        end
        return res;
    endfunction

    // Offer one instruction after a random gap; the model steps on acceptance
    task automatic send_instr(input logic [BYTE_W-1:0] f, l, r,
                              input bit use_typed, input result_t typed_res);
        int gap;
        result_t predicted;
        if (total_items % 32 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk) instr_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        instr_ch.valid <= 1'b1;
        instr_ch.func  <= f;
        instr_ch.left  <= l;
        instr_ch.right <= r;
        do
            @(posedge clk);
        while (instr_ch.ready !== 1'b1);
        predicted = predict_execute(f, l, r);
        expected_results.push_back(use_typed ? typed_res : predicted);
        total_items++;
    endtask

    // Jump target below the current code_limit, extremes favored
    function automatic logic [BYTE_W-1:0] jump_target();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return m_limit - 8'd1;
            default: return 8'($urandom_range(0, int'(m_limit) - 1));
        endcase
    endfunction

    // Random program that keeps running: registers, stack and ip stay legal
    task automatic run_random(input int count);
        logic [BYTE_W-1:0] f, l, r;
        int pick;
        repeat (count)
        begin
            l = 8'($urandom);
            r = 8'($urandom);
            if (random_items == LONG_HOLD_AT)
                long_hold_req = 1'b1;
            if (int'(m_ip) + int'(IP_STEP) >= int'(m_limit))
            begin
                // no room to fall through: branch back below the limit
                f = (m_flag == FLAG_EQ && $urandom_range(0, 1) == 1) ? OP_JE : OP_JMP;
                l = jump_target();
            end
            else
            begin
                pick = $urandom_range(0, OPCODE_COUNT - 2);
                if (pick >= OP_STP)
                    pick++;     // stop is kept for the ending
                if (push_burst > 0)
                begin
                    pick = OP_PUSH;
                    push_burst--;
                end
                else if ($urandom_range(0, 39) == 0)
                    push_burst = STACK_DEPTH;
                if (pick == OP_PUSH && m_sp == STACK_DEPTH)
                begin
                    pick = OP_POP;
                    push_burst = 0;
                end
                if (pick == OP_POP && m_sp == 0)
                    pick = OP_PUSH;
                f = 8'(pick);
                case (op_t'(f))
                    OP_DIV, OP_MOD:
                        if ($urandom_range(0, 7) == 0)
                            r = 8'd0;
                    OP_LDI, OP_ADR, OP_SUR, OP_INC, OP_DEC:
                        l = 8'($urandom_range(0, REG_COUNT - 1));
                    OP_JMP:
                        l = jump_target();
                    OP_JE:
                        if (m_flag == FLAG_EQ)
                            l = jump_target();
                    OP_CMP:
                        if ($urandom_range(0, 3) != 0)
                        begin
                            l = 8'($urandom_range(0, REG_COUNT - 1));
                            r = 8'($urandom_range(0, REG_COUNT - 1));
                        end
                    OP_STI:
                        if ($urandom_range(0, 3) != 0)
                            l = 8'($urandom_range(0, DATA_BYTES - 1));
                    OP_LDM, OP_POP:
                        if ($urandom_range(0, 3) != 0)
                        begin
                            l = 8'($urandom_range(0, REG_COUNT - 1));
                            r = 8'($urandom_range(0, DATA_BYTES - 1));
                        end
                    default: ;
                endcase
            end
            send_instr(f, l, r, 1'b0, blank_result);
            random_items++;
        end
    endtask

    // Bring ip home, drain, then write code_limit while nothing is in flight
    task automatic set_code_limit(input logic [BYTE_W-1:0] limit);
        if (!m_halted)
            send_instr(OP_JMP, 8'd0, 8'd0, 1'b0, blank_result);
        @(negedge clk) instr_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk) cfg_wr_en <= 1'b0;
        m_limit = limit;
        limit_writes++;
    endtask

    // Result side ready: random stalls, one long hold to back up the input
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall_left    = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Compare one field and report a mismatch
    task automatic check_field(input string field, input logic signed [31:0] want, got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: result %0d %s expected %0d, got %0d",
                     $time, results_seen, field, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (results_seen % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: result %0d arrived with none expected", $time, results_seen);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("value", want.value, result_ch.value);
                check_field("next_ip", {23'd0, want.next_ip}, {23'd0, result_ch.next_ip});
                check_field("status", {29'd0, want.status}, {29'd0, result_ch.status});
                check_field("exit_code", {24'd0, want.exit_code}, {24'd0, result_ch.exit_code});
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        instr_ch.valid = 1'b0;
        instr_ch.func  = '0;
        instr_ch.left  = '0;
        instr_ch.right = '0;
        foreach (m_regs[i])
            m_regs[i] = '0;
        foreach (m_dmem[i])
            m_dmem[i] = '0;
        foreach (m_stack[i])
            m_stack[i] = '0;
        m_flag   = FLAG_POS;
        m_ip     = '0;
        m_sp     = 0;
        m_halted = 1'b0;
        m_limit  = CODE_LIMIT_RST;
        blank_result = '{value: '0, next_ip: '0, status: ST_RUN, exit_code: '0};

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed table: extremes, every opcode except STP, unmapped registers and addresses
        foreach (directed_rows[i])
            send_instr(directed_rows[i].op, directed_rows[i].left, directed_rows[i].right,
                       directed_rows[i].typed, directed_rows[i].want);

        // Random programs under several code limits
        set_code_limit(8'd255);
        run_random(200);
        set_code_limit(8'd4);
        run_random(90);
        set_code_limit(8'($urandom_range(8, 254)));
        run_random(200);

        // One terminal condition per run, picked at random
        set_code_limit(8'd255);
        ending = status_t'($urandom_range(int'(ST_STOP), int'(ST_UNDER)));
        case (ending)
            ST_STOP:
                send_instr(OP_STP, 8'($urandom), 8'($urandom), 1'b0, blank_result);
            ST_BADOP:
                send_instr(8'($urandom_range(OPCODE_COUNT, 255)), 8'($urandom),
                           8'($urandom), 1'b0, blank_result);
            ST_BADREG:
                send_instr(8'($urandom_range(int'(OP_LDI), int'(OP_DEC))),
                           8'($urandom_range(REG_COUNT, 255)), 8'($urandom), 1'b0, blank_result);
            ST_OVER:
            begin
                while (m_sp < STACK_DEPTH)
                    send_instr(OP_PUSH, 8'($urandom), 8'($urandom), 1'b0, blank_result);
                send_instr(OP_PUSH, 8'($urandom), 8'($urandom), 1'b0, blank_result);
            end
            ST_UNDER:
            begin
                while (m_sp > 0)
                    send_instr(OP_POP, 8'($urandom_range(0, REG_COUNT - 1)), 8'($urandom),
                               1'b0, blank_result);
                send_instr(OP_POP, 8'($urandom), 8'($urandom), 1'b0, blank_result);
            end
            default:
            begin
                // run off the end: last legal ip, fall through past 255
                send_instr(OP_JMP, 8'd254, 8'($urandom), 1'b0, blank_result);
                send_instr(OP_ADD, 8'($urandom), 8'($urandom), 1'b0, blank_result);
                send_instr(OP_ADD, 8'($urandom), 8'($urandom), 1'b0, blank_result);
            end
        endcase

        // Halted: everything is ignored, any opcode byte
        repeat (6)
        begin
            send_instr(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, blank_result);
            halted_items++;
        end
        set_code_limit(8'd0);
        repeat (6)
        begin
            send_instr(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, blank_result);
            halted_items++;
        end

        @(negedge clk) instr_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d instructions (%0d random, %0d while halted), %0d results checked,",
                 total_items, random_items, halted_items, results_seen);
        $display("%0d code_limit writes; program ended on status %s.",
                 limit_writes, ending.name());
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_if.sv
hw/rtl/bvm_divider.sv
hw/rtl/bvm_controller.sv
hw/rtl/bvm_datapath.sv
hw/rtl/byte_vm_instruction_execute.sv
hw/rtl/bvm_checker.sv
bench/testbench.sv
